// ===== src/sqs_pkg.sv =====
package sqs_pkg;

    // screen size used for culling
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    // field widths
    localparam int POS_W   = 16;
    localparam int SRC_W   = 10;
    localparam int EXT_W   = 11;
    localparam int TEX_W   = 16;
    localparam int TSIZE_W = 11;
    localparam int EDGE_W  = 13;
    localparam int UV_W    = 18;

    // divider geometry: numerator is a texel position plus an extent
    localparam int NUM_W       = SRC_W + 2;
    localparam int DEN_W       = TSIZE_W;
    localparam int QUO_W       = UV_W;
    localparam int DIV_BITS    = 3;
    localparam int DIV_STEPS   = QUO_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int FRAC_W      = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     visible;
        logic signed [EDGE_W-1:0] x_first;
        logic signed [EDGE_W-1:0] x_second;
        logic signed [EDGE_W-1:0] y_first;
        logic signed [EDGE_W-1:0] y_second;
    } edge_res_t;

endpackage

// ===== src/sqs_div.sv =====
module sqs_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sqs_pkg::div_req_t            req,
    output logic                         done,
    output logic [sqs_pkg::QUO_W-1:0]    quo
);

    logic                                busy_reg, busy_next;
    logic [sqs_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [sqs_pkg::DEN_W-1:0]           rem_reg, rem_next;
    logic [sqs_pkg::QUO_W-1:0]           dvd_reg, dvd_next;
    logic [sqs_pkg::QUO_W-1:0]           quo_reg, quo_next;
    logic [sqs_pkg::DEN_W-1:0]           den_reg, den_next;
    logic                                sat_reg, sat_next;
    logic [sqs_pkg::DEN_W-1:0]           step_rem;
    logic [sqs_pkg::DIV_BITS-1:0]        step_q;

    // DIV_BITS restoring-division quotient bits per cycle
    always_comb begin
        logic [sqs_pkg::DEN_W:0] trial;
        step_rem = rem_reg;
        step_q   = '0;
        for (int i = 0; i < sqs_pkg::DIV_BITS; i++) begin
            trial = {step_rem, dvd_reg[sqs_pkg::QUO_W-1-i]};
            if (trial >= {1'b0, den_reg}) begin
                trial = trial - {1'b0, den_reg};
                step_q[sqs_pkg::DIV_BITS-1-i] = 1'b1;
            end
            step_rem = trial[sqs_pkg::DEN_W-1:0];
        end
    end

    assign done = busy_reg && (cnt_reg == sqs_pkg::DIV_CNT_W'(sqs_pkg::DIV_STEPS - 1));
    assign quo  = sat_reg ? '1
                          : {quo_reg[sqs_pkg::QUO_W-sqs_pkg::DIV_BITS-1:0], step_q};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        sat_next  = sat_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            // upper numerator bits give the first partial remainder
            rem_next  = sqs_pkg::DEN_W'(req.num[sqs_pkg::NUM_W-1:2]);
            dvd_next  = {req.num[1:0], {sqs_pkg::FRAC_W{1'b0}}};
            quo_next  = '0;
            den_next  = req.den;
            // quotient reaches 4.0 (or the size is zero)
            sat_next  = {1'b0, req.num} >= {req.den, 2'b00};
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            rem_next = step_rem;
            dvd_next = dvd_reg << sqs_pkg::DIV_BITS;
            quo_next = {quo_reg[sqs_pkg::QUO_W-sqs_pkg::DIV_BITS-1:0], step_q};
            if (done) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        sat_reg <= sat_next;
    end

endmodule

// ===== src/sqs_edge.sv =====
module sqs_edge (
    input  logic signed [sqs_pkg::POS_W-1:0] pos_x,
    input  logic signed [sqs_pkg::POS_W-1:0] pos_y,
    input  logic [sqs_pkg::EXT_W-1:0]        src_w,
    input  logic [sqs_pkg::EXT_W-1:0]        src_h,
    input  logic [1:0]                       flip_bits,
    input  logic                             double_scale,
    output sqs_pkg::edge_res_t               res
);

    localparam int PW = sqs_pkg::POS_W + 1;
    localparam int SW = sqs_pkg::POS_W + 2;

    logic signed [PW-1:0]         px, py;
    logic [sqs_pkg::EXT_W:0]      ew, eh;
    logic signed [SW-1:0]         x0, x1, y0, y1;

    function automatic logic signed [sqs_pkg::EDGE_W-1:0] clamp(
        input logic signed [SW-1:0] v
    );
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        lo = SW'(-(2 ** (sqs_pkg::EDGE_W - 1)));
        hi = SW'(2 ** (sqs_pkg::EDGE_W - 1) - 1);
        if (v < lo) begin
            return lo[sqs_pkg::EDGE_W-1:0];
        end else if (v > hi) begin
            return hi[sqs_pkg::EDGE_W-1:0];
        end
        return v[sqs_pkg::EDGE_W-1:0];
    endfunction

    always_comb begin
        px = double_scale ? {pos_x, 1'b0} : PW'(pos_x);
        py = double_scale ? {pos_y, 1'b0} : PW'(pos_y);
        ew = double_scale ? {src_w, 1'b0} : {1'b0, src_w};
        eh = double_scale ? {src_h, 1'b0} : {1'b0, src_h};
        x0 = SW'(px);
        y0 = SW'(py);
        x1 = x0 + $signed({{(SW-sqs_pkg::EXT_W-1){1'b0}}, ew});
        y1 = y0 + $signed({{(SW-sqs_pkg::EXT_W-1){1'b0}}, eh});

        res.visible = (px < PW'(sqs_pkg::SCREEN_WIDTH)) && (py < PW'(sqs_pkg::SCREEN_HEIGHT))
                      && (x1 > 0) && (y1 > 0);
        res.x_first  = flip_bits[0] ? clamp(x1) : clamp(x0);
        res.x_second = flip_bits[0] ? clamp(x0) : clamp(x1);
        res.y_first  = flip_bits[1] ? clamp(y1) : clamp(y0);
        res.y_second = flip_bits[1] ? clamp(y0) : clamp(y1);
    end

endmodule

// ===== src/sprite_quad_setup.sv =====
// sprite quad setup
// one sprite per input transfer on the s_ channel; one quad (edges, texture
// coordinates, load-texture flag) per drawn sprite on the m_ channel. hidden
// sprites and sprites wholly off screen give no output transfer.
// cfg_we/cfg_wdata write the double-scale register; write only while idle.
// sequence: after an input transfer the block passes through a setup state for
// culling, edges and texture tracking, then the shared divider computes
// u_start, u_end, v_start and v_end in turn (three quotient bits per cycle),
// and m_tvalid rises once the last quotient is stored. a dropped sprite takes
// the block from setup straight back to idle. one sprite is in flight at a
// time: s_tready is high only while idle, so no new sprite is taken while the
// single divider works on a drawn sprite.
// if the receiver stalls, the result is held in the output registers and no
// new sprite is taken until the output transfer completes.
// reset (aresetn low, synchronous) clears double-scale and forgets the
// remembered texture, so the first drawn sprite raises load_texture.
module sprite_quad_setup (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_we,
    input  logic         cfg_wdata,      // double_scale
    // sprite input
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, src_x, src_y, src_w, src_h, tex_id, tex_w, tex_h
    input  logic [111:0] s_tdata,
    // hidden, flip_bits[1:0]
    input  logic [2:0]   s_tuser,
    input  logic         s_tlast,        // last_in_batch
    // quad output
    output logic         m_tvalid,
    input  logic         m_tready,
    // x_first, x_second, y_first, y_second, u_start, u_end, v_start, v_end,
    // four zero bits
    output logic [127:0] m_tdata,
    output logic [0:0]   m_tuser         // load_texture
);

    sqs_pkg::state_t state_reg, state_next;

    logic                                    ds_reg;
    logic signed [sqs_pkg::POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic [sqs_pkg::SRC_W-1:0]               src_x_reg, src_y_reg;
    logic [sqs_pkg::EXT_W-1:0]               src_w_reg, src_h_reg;
    logic [sqs_pkg::TEX_W-1:0]               tex_id_reg;
    logic [sqs_pkg::TSIZE_W-1:0]             tex_w_reg, tex_h_reg;
    logic                                    hidden_reg, last_reg;
    logic [1:0]                              flip_reg;

    logic [sqs_pkg::TEX_W-1:0]               mem_tex_reg;
    logic                                    mem_valid_reg;
    logic                                    load_reg;
    logic signed [sqs_pkg::EDGE_W-1:0]       xf_reg, xs_reg, yf_reg, ys_reg;
    logic [sqs_pkg::UV_W-1:0]                uv_reg [4];
    logic [1:0]                              qidx_reg;

    logic                                    accept;
    logic                                    draw;
    logic [1:0]                              op_idx;
    logic                                    div_start;
    sqs_pkg::div_req_t                       div_req;
    logic                                    div_done;
    logic [sqs_pkg::QUO_W-1:0]               div_quo;
    sqs_pkg::edge_res_t                      edge_res;

    assign s_tready = (state_reg == sqs_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sqs_pkg::ST_OUT);
    assign accept   = s_tvalid && s_tready;
    assign draw     = !hidden_reg && edge_res.visible;

    assign m_tdata = {4'b0000, uv_reg[3], uv_reg[2], uv_reg[1], uv_reg[0],
                      ys_reg, yf_reg, xs_reg, xf_reg};
    assign m_tuser = load_reg;

    // culling and quad edges from the held sprite
    sqs_edge u_edge (
        .pos_x        (pos_x_reg),
        .pos_y        (pos_y_reg),
        .src_w        (src_w_reg),
        .src_h        (src_h_reg),
        .flip_bits    (flip_reg),
        .double_scale (ds_reg),
        .res          (edge_res)
    );

    // operand select for the shared divider: u_start, u_end, v_start, v_end
    always_comb begin
        div_req.start = div_start;
        unique case (op_idx)
            2'd0: div_req.num = sqs_pkg::NUM_W'(src_x_reg);
            2'd1: div_req.num = sqs_pkg::NUM_W'(src_x_reg) + sqs_pkg::NUM_W'(src_w_reg);
            2'd2: div_req.num = sqs_pkg::NUM_W'(src_y_reg);
            2'd3: div_req.num = sqs_pkg::NUM_W'(src_y_reg) + sqs_pkg::NUM_W'(src_h_reg);
            default: div_req.num = '0;
        endcase
        div_req.den = op_idx[1] ? tex_h_reg : tex_w_reg;
    end

    sqs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        op_idx     = qidx_reg + 2'd1;
        unique case (state_reg)
            sqs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sqs_pkg::ST_SETUP;
                end
            end
            sqs_pkg::ST_SETUP: begin
                op_idx = 2'd0;
                if (draw) begin
                    div_start  = 1'b1;
                    state_next = sqs_pkg::ST_DIV;
                end else begin
                    state_next = sqs_pkg::ST_IDLE;
                end
            end
            sqs_pkg::ST_DIV: begin
                if (div_done) begin
                    if (qidx_reg == 2'd3) begin
                        state_next = sqs_pkg::ST_OUT;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            sqs_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = sqs_pkg::ST_IDLE;
                end
            end
            default: state_next = sqs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sqs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration and texture tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ds_reg        <= 1'b0;
            mem_tex_reg   <= '0;
            mem_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                ds_reg <= cfg_wdata;
            end
            if (state_reg == sqs_pkg::ST_SETUP) begin
                if (draw) begin
                    mem_tex_reg <= tex_id_reg;
                end
                // end of batch forgets the texture, drawn or not
                if (last_reg) begin
                    mem_valid_reg <= 1'b0;
                end else if (draw) begin
                    mem_valid_reg <= 1'b1;
                end
            end
        end
    end

    // sprite capture and result registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_x_reg  <= s_tdata[15:0];
            pos_y_reg  <= s_tdata[31:16];
            src_x_reg  <= s_tdata[41:32];
            src_y_reg  <= s_tdata[51:42];
            src_w_reg  <= s_tdata[62:52];
            src_h_reg  <= s_tdata[73:63];
            tex_id_reg <= s_tdata[89:74];
            tex_w_reg  <= s_tdata[100:90];
            tex_h_reg  <= s_tdata[111:101];
            hidden_reg <= s_tuser[0];
            flip_reg   <= s_tuser[2:1];
            last_reg   <= s_tlast;
        end
        if (state_reg == sqs_pkg::ST_SETUP) begin
            xf_reg   <= edge_res.x_first;
            xs_reg   <= edge_res.x_second;
            yf_reg   <= edge_res.y_first;
            ys_reg   <= edge_res.y_second;
            load_reg <= !mem_valid_reg || (mem_tex_reg != tex_id_reg);
            qidx_reg <= 2'd0;
        end else if (state_reg == sqs_pkg::ST_DIV && div_done) begin
            uv_reg[qidx_reg] <= div_quo;
            qidx_reg         <= qidx_reg + 2'd1;
        end
    end

    // input and output sides never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // the divider only finishes while quotients are being collected
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == sqs_pkg::ST_DIV))
        else $error("divider finished outside the divide phase");

    // a zero texture width saturates both u coordinates
    a_u_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (tex_w_reg == '0)) |-> ((&uv_reg[0]) && (&uv_reg[1])))
        else $error("u coordinates not saturated for zero texture width");

    // a drawn sprite enters the divide phase with the first quotient slot
    a_setup_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sqs_pkg::ST_SETUP && draw) |=>
            (state_reg == sqs_pkg::ST_DIV && qidx_reg == 2'd0))
        else $error("drawn sprite did not start division");

endmodule
